[src/assert_macros.svh]
// Assertion macros used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define U2DA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("u2da assertion failed");
`define U2DA_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("u2da forbidden condition seen");
`else
`define U2DA_ASSERT(lbl, clk, rst_n, prop)
`define U2DA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[src/u2da_pkg.sv]
// Shared constants and types of the binary to decimal ASCII converter.
package u2da_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 6;
  localparam int DIGIT_W        = 4;
  localparam int DIGIT_SLOTS    = 10;
  localparam int MAX_DIGITS_DEF = 10;
  localparam int CNT_W          = $clog2(DIGIT_SLOTS + 1);

  // Exact divide by ten for 32-bit operands: q = (n * RECIP_10) >> RECIP_SHIFT
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 Q_W         = 2 * VALUE_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'h30;

  // Control that travels with each request through the pipeline
  typedef struct packed {
    logic             valid;
    logic             live;   // this stage still produces a digit (always set at the first stage)
    logic [CNT_W-1:0] count;  // digits produced so far
  } u2da_ctl_t;

endpackage

[src/u2da_div_stage.sv]
// One digit stage: reciprocal multiply, then remainder extraction.
module u2da_div_stage
  import u2da_pkg::*;
#(
  parameter int SLOT  = 0,
  parameter int NSLOT = DIGIT_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  u2da_ctl_t                  ctl_i,
  input  logic [VALUE_W-1:0]         value_i,
  input  logic [NSLOT*DIGIT_W-1:0]   digits_i,
  output u2da_ctl_t                  ctl_o,
  output logic [VALUE_W-1:0]         value_o,
  output logic [NSLOT*DIGIT_W-1:0]   digits_o
);

  logic [2*VALUE_W-1:0]       prod;
  u2da_ctl_t                  ctl_a_r;
  logic [Q_W-1:0]             q_a_r;
  logic [DIGIT_W-1:0]         nlo_a_r;
  logic [NSLOT*DIGIT_W-1:0]   dig_a_r;

  logic [DIGIT_W-1:0]         times10_lo;
  logic [DIGIT_W-1:0]         digit;
  u2da_ctl_t                  ctl_b_nxt;
  logic [NSLOT*DIGIT_W-1:0]   dig_b_nxt;
  u2da_ctl_t                  ctl_b_r;
  logic [VALUE_W-1:0]         val_b_r;
  logic [NSLOT*DIGIT_W-1:0]   dig_b_r;

  assign prod = {{VALUE_W{1'b0}}, value_i} * {{VALUE_W{1'b0}}, RECIP_10};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (adv) begin
      ctl_a_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_a_r   <= prod[2*VALUE_W-1:RECIP_SHIFT];
      nlo_a_r <= value_i[DIGIT_W-1:0];
      dig_a_r <= digits_i;
    end
  end

  // Remainder needs only the low nibble: n - 10q is always 0..9
  always_comb begin
    times10_lo = DIGIT_W'({q_a_r[2:0], 1'b0}) + DIGIT_W'({q_a_r[0], 3'b000});
    digit      = nlo_a_r - times10_lo;
    ctl_b_nxt  = ctl_a_r;
    dig_b_nxt  = dig_a_r;
    if (ctl_a_r.live) begin
      ctl_b_nxt.count = CNT_W'(SLOT + 1);
      dig_b_nxt[SLOT*DIGIT_W +: DIGIT_W] = digit;
    end
    ctl_b_nxt.live = ctl_a_r.live && (q_a_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (adv) begin
      ctl_b_r <= ctl_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_b_r <= VALUE_W'(q_a_r);
      dig_b_r <= dig_b_nxt;
    end
  end

  assign ctl_o    = ctl_b_r;
  assign value_o  = val_b_r;
  assign digits_o = dig_b_r;

endmodule

[src/u2da_emit.sv]
// Digit emitter: sends one ASCII digit per cycle, most significant first.
module u2da_emit
  import u2da_pkg::*;
#(
  parameter int CAP = DIGIT_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  u2da_ctl_t                tail_i,
  input  logic [CAP*DIGIT_W-1:0]   digits_i,
  output logic                     adv_o,
  output logic                     out_strobe,
  output logic [CHAR_W-1:0]        out_digit_char,
  output logic                     out_last_digit
);

  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

  logic               act_r;
  logic               act_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   idx_nxt;
  logic [DIGIT_W-1:0] dig_r [CAP];
  logic               take;
  logic               load;

  assign take  = !act_r || (idx_r == '0);
  assign load  = take && tail_i.valid;
  assign adv_o = !tail_i.valid || take;

  always_comb begin
    act_nxt = act_r;
    idx_nxt = idx_r;
    if (load) begin
      act_nxt = 1'b1;
      idx_nxt = IDX_W'(tail_i.count - CNT_W'(1));
    end else if (take) begin
      act_nxt = 1'b0;
    end else begin
      idx_nxt = idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
    end else begin
      act_r <= act_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < CAP; i++) begin
        dig_r[i] <= digits_i[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign out_strobe     = act_r;
  assign out_digit_char = ASCII_ZERO + CHAR_W'(dig_r[idx_r]);
  assign out_last_digit = act_r && (idx_r == '0);

endmodule

[src/unsigned_to_decimal_ascii.sv]
// Top level of the unsigned binary to decimal ASCII converter.
// Converts a 32-bit unsigned value to ASCII decimal digits, most significant first,
// no leading zeros (zero gives a single '0'); out_last_digit marks the final digit of
// each run. A request is taken when start is high and busy is low. The value passes a
// pipeline of two register stages per digit (a 32x32 reciprocal multiply, then the
// remainder) and then the emitter's digit register before its first digit appears.
// Digits then leave one per cycle on out_strobe; the receiver cannot stall them. The
// output port sets throughput: with the pipeline full, a new request is taken only while
// the last digit of the current run is on the output; until then the pipeline holds.
// With MAX_DIGITS below the digit count only the low MAX_DIGITS digits are sent.
`include "assert_macros.svh"
module unsigned_to_decimal_ascii
  import u2da_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_strobe,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  localparam int CAP = (MAX_DIGITS < DIGIT_SLOTS) ? MAX_DIGITS : DIGIT_SLOTS;

  logic                    adv;
  u2da_ctl_t               ctl     [CAP+1];
  logic [VALUE_W-1:0]      value   [CAP+1];
  logic [CAP*DIGIT_W-1:0]  digits  [CAP+1];

  assign ctl[0]    = {start, 1'b1, CNT_W'(0)};
  assign value[0]  = in_value;
  assign digits[0] = '0;

  for (genvar s = 0; s < CAP; s++) begin : g_stage
    u2da_div_stage #(
      .SLOT  (s),
      .NSLOT (CAP)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .ctl_i    (ctl[s]),
      .value_i  (value[s]),
      .digits_i (digits[s]),
      .ctl_o    (ctl[s+1]),
      .value_o  (value[s+1]),
      .digits_o (digits[s+1])
    );
  end

  u2da_emit #(
    .CAP (CAP)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .tail_i         (ctl[CAP]),
    .digits_i       (digits[CAP]),
    .adv_o          (adv),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  assign busy = !adv;

  `U2DA_ASSERT(a_char_range, clk, rst_n, out_strobe |-> (out_digit_char <= ASCII_ZERO + CHAR_W'(9)))
  `U2DA_ASSERT(a_run_unbroken, clk, rst_n, (out_strobe && !out_last_digit) |=> out_strobe)
  `U2DA_ASSERT(a_busy_mid_run, clk, rst_n, busy |-> (out_strobe && !out_last_digit))

endmodule

[test/digit_stream_checker.sv]
// Checker for the converter: predicts the digit stream of each request and compares it.
module digit_stream_checker
  import u2da_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_strobe,
  input  logic [CHAR_W-1:0]  out_digit_char,
  input  logic               out_last_digit,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_result_t;

  digit_result_t digits_due[$];
  int unsigned   request_count;
  int unsigned   digit_count;

  task automatic report_mismatch(input string what);
    $display("digit %0d (requests taken %0d): %s", digit_count, request_count, what);
    mismatches++;
  endtask

  // Divide by ten with shifts and adds, one correction step, low digit first.
  function automatic void predict_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] n;
    logic [VALUE_W-1:0] est;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] rem;
    logic [DIGIT_W-1:0] low_first[DIGIT_SLOTS];
    int                 count;
    int                 emit;
    digit_result_t      res;
    n     = value;
    count = 0;
    do begin
      est  = n >> 1;
      est  = est + (est >> 1);
      est  = est + (est >> 4);
      est  = est + (est >> 8);
      est  = est + (est >> 16);
      quot = est >> 3;
      rem  = n - ((quot << 1) + (est & ~32'd7));
      if (rem > 9) begin
        rem  = rem - 10;
        quot = quot + 1;
      end
      low_first[count] = rem[DIGIT_W-1:0];
      count++;
      n = quot;
    end while (n != 0 && count < DIGIT_SLOTS);
    // a short digit buffer keeps only the low digits
    emit = (count > MAX_DIGITS) ? MAX_DIGITS : count;
    for (int k = 0; k < emit; k++) begin
      res.digit_char = ASCII_ZERO + CHAR_W'(low_first[emit-1-k]);
      res.last_digit = (k == emit - 1);
      digits_due.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    digit_result_t want;
    if (!rst_n) begin
      digits_due.delete();
      mismatches    = 0;
      pending       = 0;
      request_count = 0;
      digit_count   = 0;
    end else begin
      if (start && !busy) begin
        predict_digits(in_value);
        request_count++;
      end
      if (out_strobe) begin
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("unexpected digit char=%0h last=%0b",
                                    out_digit_char, out_last_digit));
        end else begin
          want = digits_due.pop_front();
          if (out_digit_char !== want.digit_char) begin
            report_mismatch($sformatf("digit_char %0h, predicted %0h",
                                      out_digit_char, want.digit_char));
          end
          if (out_last_digit !== want.last_digit) begin
            report_mismatch($sformatf("last_digit %0b, predicted %0b",
                                      out_last_digit, want.last_digit));
          end
        end
        digit_count++;
      end
      pending = digits_due.size();
    end
  end

endmodule

[test/tb_top.sv]
// Testbench top for the converter: clock, reset, request stimulus and verdict.
module tb_top;
  import u2da_pkg::*;

  localparam int          DIGITS_CFG  = MAX_DIGITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          N_RANDOM    = 300;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] in_value;
  logic               out_strobe;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last_digit;
  int unsigned        mismatches;
  int unsigned        pending;
  int unsigned        cycle_count = 0;

  unsigned_to_decimal_ascii #(
    .MAX_DIGITS(DIGITS_CFG)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit)
  );

  digit_stream_checker #(
    .MAX_DIGITS(DIGITS_CFG)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("unsigned_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  // Present a request and hold it until the block takes it.
  task automatic send_request(input logic [VALUE_W-1:0] value);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a few cycles, with noise on the value port.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start    <= 1'b0;
      in_value <= $urandom;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Random value with a chosen number of decimal digits.
  function automatic logic [VALUE_W-1:0] value_of_length(input int ndigits);
    longint unsigned lo;
    longint unsigned hi;
    lo = 1;
    repeat (ndigits - 1) lo = lo * 10;
    hi = (ndigits == DIGIT_SLOTS) ? 64'hFFFF_FFFF : lo * 10 - 1;
    if (ndigits == 1) lo = 0;
    case ($urandom_range(0, 7))
      0: return lo[VALUE_W-1:0];
      1: return hi[VALUE_W-1:0];
      default: return $urandom_range(hi[VALUE_W-1:0], lo[VALUE_W-1:0]);
    endcase
  endfunction

  initial begin
    logic [VALUE_W-1:0] corner[$];
    int                 sent;
    int                 burst;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    corner   = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd19, 32'd99, 32'd100, 32'd101,
                 32'd999, 32'd1000, 32'd9999, 32'd10000, 32'd99999, 32'd100000,
                 32'd999999, 32'd1000000, 32'd9999999, 32'd10000000, 32'd99999999,
                 32'd100000000, 32'd999999999, 32'd1000000000, 32'hFFFF_FFFF,
                 32'hFFFF_FFF6};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners back to back, then spaced out
    foreach (corner[i]) send_request(corner[i]);
    idle_gap(5);
    foreach (corner[i]) begin
      send_request(corner[i]);
      idle_gap($urandom_range(1, 12));
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_request($urandom);
        end else begin
          send_request(value_of_length($urandom_range(1, DIGIT_SLOTS)));
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
    end
    idle_gap(1);

    // drain, then watch for stray digits
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2 * DIGIT_SLOTS + 10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("unsigned_to_decimal_ascii: match");
    end else begin
      $display("unsigned_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
